>>> rtl/int128_restoring_divider_macros.svh
// ----------------------------------------------------------------------------
// int128_restoring_divider assertion macros
// Concurrent check helpers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef INT128_RESTORING_DIVIDER_MACROS_SVH
`define INT128_RESTORING_DIVIDER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define I128D_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define I128D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define I128D_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define I128D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/i128d_pkg.sv
// ----------------------------------------------------------------------------
// i128d_pkg
// Shared types and constants of the 128-bit restoring divider.
// ----------------------------------------------------------------------------
package i128d_pkg;

    localparam int HALF_W = 64;
    localparam int FULL_W = 128;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_FIX,
        ST_OUT
    } i128d_state_t;

    typedef struct packed {
        logic start;
    } i128d_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } i128d_sts_t;

endpackage

>>> rtl/i128d_if.sv
// ----------------------------------------------------------------------------
// i128d request / response channels
// Valid/ready channels carrying the operand and result words.
// ----------------------------------------------------------------------------
interface i128d_req_if;
    import i128d_pkg::*;

    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] dividend_lo;
    logic [HALF_W-1:0] dividend_hi;
    logic [HALF_W-1:0] divisor_lo;
    logic [HALF_W-1:0] divisor_hi;
    logic              signed_mode;

    modport source (
        output valid, dividend_lo, dividend_hi, divisor_lo, divisor_hi, signed_mode,
        input  ready
    );
    modport sink (
        input  valid, dividend_lo, dividend_hi, divisor_lo, divisor_hi, signed_mode,
        output ready
    );
endinterface

interface i128d_rsp_if;
    import i128d_pkg::*;

    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] quotient_lo;
    logic [HALF_W-1:0] quotient_hi;
    logic [HALF_W-1:0] remainder_lo;
    logic [HALF_W-1:0] remainder_hi;

    modport source (
        output valid, quotient_lo, quotient_hi, remainder_lo, remainder_hi,
        input  ready
    );
    modport sink (
        input  valid, quotient_lo, quotient_hi, remainder_lo, remainder_hi,
        output ready
    );
endinterface

>>> rtl/i128d_divcore.sv
// ----------------------------------------------------------------------------
// i128d_divcore
// Unsigned radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "int128_restoring_divider_macros.svh"

module i128d_divcore #(
    parameter int OPERAND_WIDTH = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  i128d_pkg::i128d_ctl_t    ctl,
    input  logic [OPERAND_WIDTH-1:0] numer,
    input  logic [OPERAND_WIDTH-1:0] denom,
    output i128d_pkg::i128d_sts_t    sts,
    output logic [OPERAND_WIDTH-1:0] quot,
    output logic [OPERAND_WIDTH-1:0] rem
);
    import i128d_pkg::*;

    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    logic [OPERAND_WIDTH-1:0] nq_reg, nq_next;     // dividend out at top, quotient in at bottom
    logic [OPERAND_WIDTH-1:0] rem_reg, rem_next;
    logic [OPERAND_WIDTH-1:0] den_reg, den_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic [OPERAND_WIDTH:0]   shifted;
    logic [OPERAND_WIDTH+1:0] diff;
    logic                     borrow;

    // shared subtractor: partial remainder shifted left with the next dividend bit, minus divisor
    assign shifted = {rem_reg, nq_reg[OPERAND_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign borrow  = diff[OPERAND_WIDTH+1];

    always_comb
    begin
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            nq_next   = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = CNT_W'(OPERAND_WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!borrow)
            begin
                rem_next = diff[OPERAND_WIDTH-1:0];
                nq_next  = {nq_reg[OPERAND_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[OPERAND_WIDTH-1:0];
                nq_next  = {nq_reg[OPERAND_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = nq_reg;
    // zero divisor: the loop leaves all ones in the quotient, remainder forced to zero
    assign rem      = (den_reg == '0) ? '0 : rem_reg;

    `I128D_ASSERT_NEXT(a_last_step_done, clk, rst_n, busy_reg && cnt_reg == '0 && !ctl.start,
        done_reg && !busy_reg, "divcore: last step did not finish")
    `I128D_ASSERT_IMPL(a_done_not_busy, clk, rst_n, done_reg, !busy_reg,
        "divcore: done while still busy")
    `I128D_ASSERT_NEXT(a_start_clears, clk, rst_n, ctl.start,
        busy_reg && rem_reg == '0 && cnt_reg == CNT_W'(OPERAND_WIDTH - 1),
        "divcore: start did not load")
    `I128D_ASSERT_IMPL(a_no_restart, clk, rst_n, ctl.start, !busy_reg,
        "divcore: start while busy")

endmodule

>>> rtl/int128_restoring_divider.sv
// ----------------------------------------------------------------------------
// int128_restoring_divider
// Signed/unsigned 128-bit divider returning quotient and remainder.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink): dividend and divisor as 64-bit halves plus signed_mode. A word
//   is taken when req.valid and req.ready are high at a rising edge of clk.
//   rsp (source): quotient and remainder as 64-bit halves, handed over when
//   rsp.valid and rsp.ready are both high.
//   Operand bits above OPERAND_WIDTH are ignored; result bits above it are 0.
//   After the accept edge the word passes ST_PREP (operand sign fix, core
//   start), ST_RUN (the shared subtract/shift unit at one quotient bit per
//   cycle, then handing over on the core's done strobe), ST_FIX (result sign
//   fix, registered) and ST_OUT, where rsp.valid is high. Only one word is in
//   flight: req.ready is high only in idle, so a new word is taken only after
//   the result has been handed over, and the bit-serial loop of the divider
//   core sets the rate at which words are taken.
//   If rsp.ready is low the result is held and req.ready stays low until it
//   is taken. rst_n (asynchronous, active low) drops any word in flight and
//   returns to idle with req.ready high.
// ----------------------------------------------------------------------------
`include "int128_restoring_divider_macros.svh"

module int128_restoring_divider #(
    parameter int OPERAND_WIDTH = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    i128d_req_if.sink    req,
    i128d_rsp_if.source  rsp
);
    import i128d_pkg::*;

    localparam logic [OPERAND_WIDTH-1:0] ONE = OPERAND_WIDTH'(1);

    i128d_state_t state_reg, state_next;

    logic [OPERAND_WIDTH-1:0] n_reg, n_next;
    logic [OPERAND_WIDTH-1:0] d_reg, d_next;
    logic                     sgn_reg, sgn_next;
    logic                     nneg_reg, nneg_next;
    logic                     dneg_reg, dneg_next;
    logic [OPERAND_WIDTH-1:0] q_out_reg, q_out_next;
    logic [OPERAND_WIDTH-1:0] r_out_reg, r_out_next;

    logic [FULL_W-1:0]        dividend_full;
    logic [FULL_W-1:0]        divisor_full;
    logic [FULL_W-1:0]        q_full;
    logic [FULL_W-1:0]        r_full;
    logic                     n_is_neg;
    logic                     d_is_neg;
    logic [OPERAND_WIDTH-1:0] n_mag;
    logic [OPERAND_WIDTH-1:0] d_mag;

    i128d_ctl_t               ctl;
    i128d_sts_t               sts;
    logic [OPERAND_WIDTH-1:0] core_q;
    logic [OPERAND_WIDTH-1:0] core_r;

    i128d_divcore #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_divcore (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .numer (n_mag),
        .denom (d_mag),
        .sts   (sts),
        .quot  (core_q),
        .rem   (core_r)
    );

    assign dividend_full = {req.dividend_hi, req.dividend_lo};
    assign divisor_full  = {req.divisor_hi, req.divisor_lo};

    assign n_is_neg = sgn_reg & n_reg[OPERAND_WIDTH-1];
    assign d_is_neg = sgn_reg & d_reg[OPERAND_WIDTH-1];
    assign n_mag    = n_is_neg ? (~n_reg + ONE) : n_reg;
    assign d_mag    = d_is_neg ? (~d_reg + ONE) : d_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sgn_next   = sgn_reg;
        nneg_next  = nneg_reg;
        dneg_next  = dneg_reg;
        q_out_next = q_out_reg;
        r_out_next = r_out_reg;
        ctl.start  = 1'b0;
        req.ready  = 1'b0;
        rsp.valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    n_next     = dividend_full[OPERAND_WIDTH-1:0];
                    d_next     = divisor_full[OPERAND_WIDTH-1:0];
                    sgn_next   = req.signed_mode;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                ctl.start  = 1'b1;
                nneg_next  = n_is_neg;
                dneg_next  = d_is_neg;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (sts.done)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                // quotient negative when signs differ, remainder follows dividend
                q_out_next = (nneg_reg ^ dneg_reg) ? (~core_q + ONE) : core_q;
                r_out_next = nneg_reg ? (~core_r + ONE) : core_r;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        sgn_reg   <= sgn_next;
        nneg_reg  <= nneg_next;
        dneg_reg  <= dneg_next;
        q_out_reg <= q_out_next;
        r_out_reg <= r_out_next;
    end

    assign q_full = FULL_W'(q_out_reg);
    assign r_full = FULL_W'(r_out_reg);

    assign rsp.quotient_lo  = q_full[HALF_W-1:0];
    assign rsp.quotient_hi  = q_full[FULL_W-1:HALF_W];
    assign rsp.remainder_lo = r_full[HALF_W-1:0];
    assign rsp.remainder_hi = r_full[FULL_W-1:HALF_W];

    `I128D_ASSERT_IMPL(a_one_in_flight, clk, rst_n, rsp.valid, !req.ready,
        "divider: input taken while result pending")
    `I128D_ASSERT_IMPL(a_done_in_run, clk, rst_n, sts.done, state_reg == ST_RUN,
        "divider: core finished outside run state")
    `I128D_ASSERT_IMPL(a_busy_in_run, clk, rst_n, sts.busy, state_reg == ST_RUN,
        "divider: core busy outside run state")

endmodule
